[src/rvbm_pkg.sv]
// shared types, constants and helpers for the rgba voxel blend unit
package rvbm_pkg;

    // channel order inside a voxel word
    localparam int NUM_CH = 4;
    localparam int NUM_COLOR = 3;
    localparam int CH_ALPHA = 3;

    // one restoring division cell per quotient bit
    localparam int DIV_CELLS = 8;

    // full-scale channel value
    localparam logic [7:0] FULL = 8'd255;

    // blend mode codes
    localparam logic [2:0] BLEND_PAINT = 3'd0;
    localparam logic [2:0] BLEND_OVER = 3'd1;
    localparam logic [2:0] BLEND_SUBTRACT = 3'd2;
    localparam logic [2:0] BLEND_MAX = 3'd3;
    localparam logic [2:0] BLEND_SUB_CLAMP = 3'd4;
    localparam logic [2:0] BLEND_MUL_ALPHA = 3'd5;
    localparam logic [2:0] BLEND_INTERSECT = 3'd6;

    // configuration register indexes
    localparam logic [2:0] REG_BLEND_MODE = 3'd0;
    localparam logic [2:0] REG_TINT_ENABLE = 3'd1;
    localparam logic [2:0] REG_TINT_RED = 3'd2;
    localparam logic [2:0] REG_TINT_GREEN = 3'd3;
    localparam logic [2:0] REG_TINT_BLUE = 3'd4;
    localparam logic [2:0] REG_TINT_ALPHA = 3'd5;

    // voxel: index 0 red, 1 green, 2 blue, 3 alpha
    typedef logic [NUM_CH-1:0][7:0] rgba_t;

    // configuration seen by the datapath
    typedef struct packed {
        logic [2:0] blend_mode;
        logic       tint_enable;
        rgba_t      tint;
    } cfg_t;

    // payload travelling down the division chain
    typedef struct packed {
        logic [NUM_COLOR-1:0][15:0] rem;
        logic [NUM_COLOR-1:0][7:0]  quot;
        logic [15:0]                den;
        rgba_t                      base;
        rgba_t                      dst;
    } div_t;

    // exact x/255 for x up to 65279
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] t;
        t = {1'b0, x} + 17'd1 + {9'd0, x[15:8]};
        return t[15:8];
    endfunction

endpackage

[src/rvbm_if.sv]
// valid/ready channel interfaces for voxel input and blended output
interface rvbm_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] dst_red;
    logic [7:0] dst_green;
    logic [7:0] dst_blue;
    logic [7:0] dst_alpha;
    logic [7:0] src_red;
    logic [7:0] src_green;
    logic [7:0] src_blue;
    logic [7:0] src_alpha;

    modport source (
        output valid, dst_red, dst_green, dst_blue, dst_alpha,
        output src_red, src_green, src_blue, src_alpha,
        input  ready
    );
    modport sink (
        input  valid, dst_red, dst_green, dst_blue, dst_alpha,
        input  src_red, src_green, src_blue, src_alpha,
        output ready
    );
endinterface

interface rvbm_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;
    logic       changed;

    modport source (
        output valid, out_red, out_green, out_blue, out_alpha, changed,
        input  ready
    );
    modport sink (
        input  valid, out_red, out_green, out_blue, out_alpha, changed,
        output ready
    );
endinterface

[src/rvbm_front.sv]
// front pipeline: tint, channel products and per-mode results
module rvbm_front (
    input  logic                clk,
    input  logic                rst_n,
    rvbm_in_if.sink             vox_in,
    input  rvbm_pkg::cfg_t      cfg,
    output logic                out_valid,
    input  logic                out_ready,
    output rvbm_pkg::div_t      out_data
);

    // stage valids and readies
    logic a_valid_reg, b_valid_reg, c_valid_reg, d_valid_reg;
    logic a_ready, b_ready, c_ready, d_ready;

    // stage a: raw voxels and tint products
    rvbm_pkg::rgba_t         a_dst_reg, a_src_reg;
    logic [3:0][15:0]        a_tprod_reg;
    rvbm_pkg::rgba_t         in_dst, in_src;
    logic [3:0][15:0]        a_tprod_next;

    // stage b: tinted source
    rvbm_pkg::rgba_t         b_dst_reg, b_src_reg;
    rvbm_pkg::rgba_t         b_src_next;

    // stage c: channel products
    rvbm_pkg::rgba_t         c_dst_reg;
    logic [7:0]              c_sa_reg;
    logic [rvbm_pkg::NUM_COLOR-1:0][7:0] c_src_reg;
    logic [2:0][15:0]        c_pss_reg, c_pdi_reg;
    logic [3:0][15:0]        c_pds_reg;
    logic [15:0]             c_dainv_reg;
    logic [2:0][15:0]        c_pss_next, c_pdi_next;
    logic [3:0][15:0]        c_pds_next;
    logic [15:0]             c_dainv_next;
    logic [7:0]              b_inv;

    // stage d: division setup and per-mode result
    rvbm_pkg::div_t          d_data_reg;
    rvbm_pkg::div_t          d_data_next;

    // backpressure chain
    assign d_ready = !d_valid_reg || out_ready;
    assign c_ready = !c_valid_reg || d_ready;
    assign b_ready = !b_valid_reg || c_ready;
    assign a_ready = !a_valid_reg || b_ready;
    assign vox_in.ready = a_ready;
    assign out_valid = d_valid_reg;
    assign out_data = d_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
            begin
                a_valid_reg <= vox_in.valid;
            end
            if (b_ready)
            begin
                b_valid_reg <= a_valid_reg;
            end
            if (c_ready)
            begin
                c_valid_reg <= b_valid_reg;
            end
            if (d_ready)
            begin
                d_valid_reg <= c_valid_reg;
            end
        end
    end

    // stage a: source times tint
    always_comb
    begin
        in_dst = {vox_in.dst_alpha, vox_in.dst_blue, vox_in.dst_green, vox_in.dst_red};
        in_src = {vox_in.src_alpha, vox_in.src_blue, vox_in.src_green, vox_in.src_red};
        for (int i = 0; i < rvbm_pkg::NUM_CH; i++)
        begin
            a_tprod_next[i] = {8'd0, in_src[i]} * {8'd0, cfg.tint[i]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_ready && vox_in.valid)
        begin
            a_dst_reg <= in_dst;
            a_src_reg <= in_src;
            a_tprod_reg <= a_tprod_next;
        end
    end

    // stage b: divide tint products by full scale, or pass the source through when tint is off
    always_comb
    begin
        for (int i = 0; i < rvbm_pkg::NUM_CH; i++)
        begin
            b_src_next[i] = cfg.tint_enable ? rvbm_pkg::div255(a_tprod_reg[i]) : a_src_reg[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_ready && a_valid_reg)
        begin
            b_dst_reg <= a_dst_reg;
            b_src_reg <= b_src_next;
        end
    end

    // stage c: products against source alpha and its complement
    always_comb
    begin
        b_inv = rvbm_pkg::FULL - b_src_reg[rvbm_pkg::CH_ALPHA];
        for (int i = 0; i < rvbm_pkg::NUM_COLOR; i++)
        begin
            c_pss_next[i] = {8'd0, b_src_reg[i]} * {8'd0, b_src_reg[rvbm_pkg::CH_ALPHA]};
            c_pdi_next[i] = {8'd0, b_dst_reg[i]} * {8'd0, b_inv};
        end
        for (int i = 0; i < rvbm_pkg::NUM_CH; i++)
        begin
            c_pds_next[i] = {8'd0, b_dst_reg[i]} * {8'd0, b_src_reg[rvbm_pkg::CH_ALPHA]};
        end
        c_dainv_next = {8'd0, b_dst_reg[rvbm_pkg::CH_ALPHA]} * {8'd0, b_inv};
    end

    // source colour is carried along for max mode
    always_ff @(posedge clk)
    begin
        if (c_ready && b_valid_reg)
        begin
            c_dst_reg <= b_dst_reg;
            c_sa_reg <= b_src_reg[rvbm_pkg::CH_ALPHA];
            c_src_reg <= b_src_reg[rvbm_pkg::NUM_COLOR-1:0];
            c_pss_reg <= c_pss_next;
            c_pdi_reg <= c_pdi_next;
            c_pds_reg <= c_pds_next;
            c_dainv_reg <= c_dainv_next;
        end
    end

    // stage d: over numerator and denominator, other modes finished here
    always_comb
    begin
        logic [24:0] num;
        logic [24:0] weighted;
        logic [16:0] den_wide;
        logic [7:0]  da;
        logic [7:0]  sa;
        logic [7:0]  sa_inv;
        rvbm_pkg::rgba_t res;

        da = c_dst_reg[rvbm_pkg::CH_ALPHA];
        sa = c_sa_reg;
        sa_inv = rvbm_pkg::FULL - sa;
        d_data_next.dst = c_dst_reg;
        den_wide = {1'b0, sa, 8'd0} - {9'd0, sa} + {1'b0, c_dainv_reg};
        d_data_next.den = den_wide[15:0];

        // over numerator: 255*s*sa + d*da*(255-sa), quotient below 256
        for (int i = 0; i < rvbm_pkg::NUM_COLOR; i++)
        begin
            weighted = {9'd0, c_pdi_reg[i]} * {17'd0, da};
            num = {1'b0, c_pss_reg[i], 8'd0} - {9'd0, c_pss_reg[i]} + weighted;
            d_data_next.rem[i] = num[23:8];
            d_data_next.quot[i] = num[7:0];
        end

        // colour stays destination unless the mode says otherwise
        res = c_dst_reg;
        case (cfg.blend_mode)
            rvbm_pkg::BLEND_PAINT:
            begin
                for (int i = 0; i < rvbm_pkg::NUM_COLOR; i++)
                begin
                    res[i] = rvbm_pkg::div255(c_pss_reg[i] + c_pdi_reg[i]);
                end
            end
            rvbm_pkg::BLEND_OVER:
            begin
                res[rvbm_pkg::CH_ALPHA] = sa + rvbm_pkg::div255(c_dainv_reg);
            end
            rvbm_pkg::BLEND_SUBTRACT:
            begin
                res[rvbm_pkg::CH_ALPHA] = (da > sa) ? da - sa : 8'd0;
            end
            rvbm_pkg::BLEND_MAX:
            begin
                for (int i = 0; i < rvbm_pkg::NUM_COLOR; i++)
                begin
                    res[i] = c_src_reg[i];
                end
                res[rvbm_pkg::CH_ALPHA] = (da > sa) ? da : sa;
            end
            rvbm_pkg::BLEND_SUB_CLAMP:
            begin
                res[rvbm_pkg::CH_ALPHA] = (da < sa_inv) ? da : sa_inv;
            end
            rvbm_pkg::BLEND_MUL_ALPHA:
            begin
                for (int i = 0; i < rvbm_pkg::NUM_CH; i++)
                begin
                    res[i] = rvbm_pkg::div255(c_pds_reg[i]);
                end
            end
            rvbm_pkg::BLEND_INTERSECT:
            begin
                res[rvbm_pkg::CH_ALPHA] = (da < sa) ? da : sa;
            end
            default:
            begin
                res = c_dst_reg;
            end
        endcase
        d_data_next.base = res;
    end

    always_ff @(posedge clk)
    begin
        if (d_ready && c_valid_reg)
        begin
            d_data_reg <= d_data_next;
        end
    end

endmodule

[src/rvbm_div_cell.sv]
// one restoring division step for the three colour channels, one pipeline slot
module rvbm_div_cell (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  rvbm_pkg::div_t   in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output rvbm_pkg::div_t   out_data
);

    logic            valid_reg;
    rvbm_pkg::div_t  data_reg;
    rvbm_pkg::div_t  data_next;

    assign in_ready = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data = data_reg;

    // shift in next numerator bit, subtract divisor when it fits
    always_comb
    begin
        logic [16:0] trial;
        logic        fits;
        data_next = in_data;
        for (int i = 0; i < rvbm_pkg::NUM_COLOR; i++)
        begin
            trial = {in_data.rem[i], in_data.quot[i][7]};
            fits = trial >= {1'b0, in_data.den};
            if (fits)
            begin
                trial = trial - {1'b0, in_data.den};
            end
            data_next.rem[i] = trial[15:0];
            data_next.quot[i] = {in_data.quot[i][6:0], fits};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

[src/rgba_voxel_blend_modes_top.sv]
// rgba voxel blend unit: config registers, front pipeline, division chain, output stage
// stages: 4 front stages, 8 division cells and 1 output register from input to result;
//   the 8-cell division chain for over mode sets the depth
// throughput: one voxel per cycle; every stage holds one transaction and stalls locally
// reset: rst_n clears all valids and sets blend_mode 0, tint off, tint colour 255
module rgba_voxel_blend_modes_top (
    input  logic        clk,
    input  logic        rst_n,
    rvbm_in_if.sink     vox_in,
    rvbm_out_if.source  vox_out,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    rvbm_pkg::cfg_t  cfg_reg;

    logic                  chain_valid [rvbm_pkg::DIV_CELLS+1];
    logic                  chain_ready [rvbm_pkg::DIV_CELLS+1];
    rvbm_pkg::div_t        chain_data  [rvbm_pkg::DIV_CELLS+1];

    logic                  out_valid_reg;
    logic                  out_ready;
    rvbm_pkg::rgba_t       out_vox_reg;
    logic                  out_changed_reg;
    rvbm_pkg::rgba_t       out_vox_next;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.blend_mode <= rvbm_pkg::BLEND_PAINT;
            cfg_reg.tint_enable <= 1'b0;
            cfg_reg.tint <= {rvbm_pkg::NUM_CH{rvbm_pkg::FULL}};
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rvbm_pkg::REG_BLEND_MODE:  cfg_reg.blend_mode <= cfg_data[2:0];
                rvbm_pkg::REG_TINT_ENABLE: cfg_reg.tint_enable <= cfg_data[0];
                rvbm_pkg::REG_TINT_RED:    cfg_reg.tint[0] <= cfg_data;
                rvbm_pkg::REG_TINT_GREEN:  cfg_reg.tint[1] <= cfg_data;
                rvbm_pkg::REG_TINT_BLUE:   cfg_reg.tint[2] <= cfg_data;
                rvbm_pkg::REG_TINT_ALPHA:  cfg_reg.tint[3] <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // tint, products and per-mode results
    rvbm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .vox_in    (vox_in),
        .cfg       (cfg_reg),
        .out_valid (chain_valid[0]),
        .out_ready (chain_ready[0]),
        .out_data  (chain_data[0])
    );

    // division chain for the over colour quotient
    for (genvar g = 0; g < rvbm_pkg::DIV_CELLS; g++)
    begin : g_cell
        rvbm_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (chain_valid[g]),
            .in_ready  (chain_ready[g]),
            .in_data   (chain_data[g]),
            .out_valid (chain_valid[g+1]),
            .out_ready (chain_ready[g+1]),
            .out_data  (chain_data[g+1])
        );
    end

    // output stage: pick over quotient, compare with destination
    assign out_ready = !out_valid_reg || vox_out.ready;
    assign chain_ready[rvbm_pkg::DIV_CELLS] = out_ready;

    always_comb
    begin
        out_vox_next = chain_data[rvbm_pkg::DIV_CELLS].base;
        if (cfg_reg.blend_mode == rvbm_pkg::BLEND_OVER &&
            chain_data[rvbm_pkg::DIV_CELLS].den != 16'd0)
        begin
            for (int i = 0; i < rvbm_pkg::NUM_COLOR; i++)
            begin
                out_vox_next[i] = chain_data[rvbm_pkg::DIV_CELLS].quot[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_ready)
        begin
            out_valid_reg <= chain_valid[rvbm_pkg::DIV_CELLS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_ready && chain_valid[rvbm_pkg::DIV_CELLS])
        begin
            out_vox_reg <= out_vox_next;
            out_changed_reg <= out_vox_next != chain_data[rvbm_pkg::DIV_CELLS].dst;
        end
    end

    assign vox_out.valid = out_valid_reg;
    assign vox_out.out_red = out_vox_reg[0];
    assign vox_out.out_green = out_vox_reg[1];
    assign vox_out.out_blue = out_vox_reg[2];
    assign vox_out.out_alpha = out_vox_reg[3];
    assign vox_out.changed = out_changed_reg;

endmodule

[tb/rgba_voxel_blend_modes_top_test.sv]
// self-checking testbench for the rgba voxel blend unit with bursty traffic and random stalls
module rgba_voxel_blend_modes_top_test;

    localparam int unsigned FULL_SCALE = 32'(rvbm_pkg::FULL);
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 30;

    // register indexes the package leaves unnamed
    localparam logic [2:0] REG_SPARE_LO = 3'd6;
    localparam logic [2:0] REG_SPARE_HI = 3'd7;

    typedef struct {
        rvbm_pkg::rgba_t dst;
        rvbm_pkg::rgba_t src;
    } voxel_pair_t;

    typedef struct {
        rvbm_pkg::rgba_t color;
        logic            changed;
    } blended_voxel_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [7:0]  cfg_data;

    rvbm_in_if  vox_in_bus ();
    rvbm_out_if vox_out_bus ();

    rgba_voxel_blend_modes_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .vox_in    (vox_in_bus),
        .vox_out   (vox_out_bus),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // predictor copy of the configuration registers
    logic [2:0]      mode_sel;
    logic            tint_on;
    rvbm_pkg::rgba_t tint_color;

    voxel_pair_t    voxel_q[$];
    blended_voxel_t blended_q[$];

    int mismatch_count = 0;
    int idle_cycles = 0;
    bit in_fire = 0;

    // traffic shaping knobs, set per phase
    int send_gap_max = 0;
    int stall_max = 0;
    int hold_off_left = 0;

    // clock
    initial clk = 1'b0;
    always #1 clk = ~clk;

    // one line per mismatch, counted
    task automatic report_mismatch(input string what);
        $display("mismatch: %s", what);
        mismatch_count++;
    endtask

    // register update as the block applies it
    task automatic apply_reg(input logic [2:0] idx, input logic [7:0] data);
        case (idx)
            rvbm_pkg::REG_BLEND_MODE:  mode_sel = data[2:0];
            rvbm_pkg::REG_TINT_ENABLE: tint_on = data[0];
            rvbm_pkg::REG_TINT_RED:    tint_color[0] = data;
            rvbm_pkg::REG_TINT_GREEN:  tint_color[1] = data;
            rvbm_pkg::REG_TINT_BLUE:   tint_color[2] = data;
            rvbm_pkg::REG_TINT_ALPHA:  tint_color[3] = data;
            default: ;
        endcase
    endtask

    // blended voxel for one transaction under the current configuration
    function automatic blended_voxel_t blend_voxel(input voxel_pair_t v);
        int unsigned d[4];
        int unsigned s[4];
        int unsigned r[4];
        int unsigned da;
        int unsigned sa;
        int unsigned den;
        blended_voxel_t res;
        for (int i = 0; i < rvbm_pkg::NUM_CH; i++)
        begin
            d[i] = 32'(v.dst[i]);
            s[i] = 32'(v.src[i]);
            if (tint_on)
                s[i] = s[i] * 32'(tint_color[i]) / FULL_SCALE;
            r[i] = d[i];
        end
        da = d[rvbm_pkg::CH_ALPHA];
        sa = s[rvbm_pkg::CH_ALPHA];
        case (mode_sel)
            rvbm_pkg::BLEND_PAINT:
                for (int i = 0; i < rvbm_pkg::NUM_COLOR; i++)
                    r[i] = (d[i] * (FULL_SCALE - sa) + s[i] * sa) / FULL_SCALE;
            rvbm_pkg::BLEND_OVER:
            begin
                den = FULL_SCALE * sa + da * (FULL_SCALE - sa);
                // zero denominator keeps the destination colour
                if (den != 0)
                    for (int i = 0; i < rvbm_pkg::NUM_COLOR; i++)
                        r[i] = (FULL_SCALE * s[i] * sa +
                                d[i] * da * (FULL_SCALE - sa)) / den;
                r[rvbm_pkg::CH_ALPHA] = sa + da * (FULL_SCALE - sa) / FULL_SCALE;
            end
            rvbm_pkg::BLEND_SUBTRACT:
                r[rvbm_pkg::CH_ALPHA] = (da > sa) ? da - sa : 32'd0;
            rvbm_pkg::BLEND_MAX:
            begin
                for (int i = 0; i < rvbm_pkg::NUM_COLOR; i++)
                    r[i] = s[i];
                r[rvbm_pkg::CH_ALPHA] = (da > sa) ? da : sa;
            end
            rvbm_pkg::BLEND_SUB_CLAMP:
                r[rvbm_pkg::CH_ALPHA] = (da < FULL_SCALE - sa) ? da : FULL_SCALE - sa;
            rvbm_pkg::BLEND_MUL_ALPHA:
                for (int i = 0; i < rvbm_pkg::NUM_CH; i++)
                    r[i] = d[i] * sa / FULL_SCALE;
            rvbm_pkg::BLEND_INTERSECT:
                r[rvbm_pkg::CH_ALPHA] = (da < sa) ? da : sa;
            default: ;
        endcase
        for (int i = 0; i < rvbm_pkg::NUM_CH; i++)
            res.color[i] = r[i][7:0];
        res.changed = (res.color != v.dst);
        return res;
    endfunction

    // channel value biased toward the extremes
    function automatic logic [7:0] rand_chan();
        case ($urandom_range(0, 9))
            0: return 8'd0;
            1: return 8'd255;
            2: return 8'd1;
            3: return 8'd254;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic voxel_pair_t rand_pair();
        voxel_pair_t v;
        for (int i = 0; i < rvbm_pkg::NUM_CH; i++)
        begin
            v.dst[i] = rand_chan();
            v.src[i] = rand_chan();
        end
        // identical voxels and equal alphas make the unchanged cases likely
        case ($urandom_range(0, 9))
            0: v.src = v.dst;
            1: v.src[rvbm_pkg::CH_ALPHA] = v.dst[rvbm_pkg::CH_ALPHA];
            default: ;
        endcase
        return v;
    endfunction

    function automatic voxel_pair_t make_pair(input rvbm_pkg::rgba_t d,
                                              input rvbm_pkg::rgba_t s);
        voxel_pair_t v;
        v.dst = d;
        v.src = s;
        return v;
    endfunction

    // register write, held for one cycle; caller lowers the enable after the last one
    task automatic write_reg(input logic [2:0] idx, input logic [7:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        apply_reg(idx, data);
        @(negedge clk);
    endtask

    // wait until nothing is pending, offered or expected
    task automatic wait_idle();
        do
            @(negedge clk);
        while (voxel_q.size() != 0 || vox_in_bus.valid || blended_q.size() != 0);
    endtask

    // driver: bursts of transactions separated by random gaps
    int burst_left = 0;
    int gap_left = 0;
    voxel_pair_t next_pair;

    always @(negedge clk)
    begin
        if (!vox_in_bus.valid || in_fire)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                vox_in_bus.valid <= 1'b0;
            end
            else if (voxel_q.size() == 0)
                vox_in_bus.valid <= 1'b0;
            else
            begin
                next_pair = voxel_q.pop_front();
                vox_in_bus.dst_red <= next_pair.dst[0];
                vox_in_bus.dst_green <= next_pair.dst[1];
                vox_in_bus.dst_blue <= next_pair.dst[2];
                vox_in_bus.dst_alpha <= next_pair.dst[3];
                vox_in_bus.src_red <= next_pair.src[0];
                vox_in_bus.src_green <= next_pair.src[1];
                vox_in_bus.src_blue <= next_pair.src[2];
                vox_in_bus.src_alpha <= next_pair.src[3];
                vox_in_bus.valid <= 1'b1;
                if (burst_left > 0)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(0, 24);
                    gap_left = (send_gap_max == 0) ? 0 : $urandom_range(0, send_gap_max);
                end
            end
        end
    end

    // receiver: alternating ready and stall runs, plus a requested long hold-off
    bit ready_phase = 1'b1;
    int run_left = 0;

    always @(negedge clk)
    begin
        if (hold_off_left > 0)
        begin
            hold_off_left--;
            vox_out_bus.ready <= 1'b0;
        end
        else if (stall_max == 0)
            vox_out_bus.ready <= 1'b1;
        else
        begin
            if (run_left == 0)
            begin
                ready_phase = !ready_phase;
                run_left = ready_phase ? $urandom_range(1, 16) : $urandom_range(1, stall_max);
            end
            else
                run_left--;
            vox_out_bus.ready <= ready_phase;
        end
    end

    // monitor: predict on input transactions, check output transactions, watchdog
    voxel_pair_t seen_pair;
    blended_voxel_t want;
    blended_voxel_t got;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            in_fire = vox_in_bus.valid && vox_in_bus.ready;
            if (in_fire)
            begin
                seen_pair.dst = {vox_in_bus.dst_alpha, vox_in_bus.dst_blue,
                                 vox_in_bus.dst_green, vox_in_bus.dst_red};
                seen_pair.src = {vox_in_bus.src_alpha, vox_in_bus.src_blue,
                                 vox_in_bus.src_green, vox_in_bus.src_red};
                blended_q.push_back(blend_voxel(seen_pair));
            end
            if (vox_out_bus.valid && vox_out_bus.ready)
            begin
                got.color = {vox_out_bus.out_alpha, vox_out_bus.out_blue,
                             vox_out_bus.out_green, vox_out_bus.out_red};
                got.changed = vox_out_bus.changed;
                if (blended_q.size() == 0)
                    report_mismatch("result transaction with none outstanding");
                else
                begin
                    want = blended_q.pop_front();
                    for (int i = 0; i < rvbm_pkg::NUM_CH; i++)
                        if (got.color[i] !== want.color[i])
                            report_mismatch($sformatf("channel %0d got %0d want %0d",
                                                      i, got.color[i], want.color[i]));
                    if (got.changed !== want.changed)
                        report_mismatch($sformatf("changed got %b want %b",
                                                  got.changed, want.changed));
                end
            end
            if (in_fire || (vox_out_bus.valid && vox_out_bus.ready) || cfg_we)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                report_mismatch($sformatf("no transaction for %0d cycles", STALL_LIMIT));
                $display("rgba_voxel_blend_modes_top regression: fail");
                $finish;
            end
        end
    end

    // stimulus
    rvbm_pkg::rgba_t zero_px;
    rvbm_pkg::rgba_t full_px;
    rvbm_pkg::rgba_t warm_px;
    rvbm_pkg::rgba_t cool_px;

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        vox_in_bus.valid = 1'b0;
        vox_in_bus.dst_red = '0;
        vox_in_bus.dst_green = '0;
        vox_in_bus.dst_blue = '0;
        vox_in_bus.dst_alpha = '0;
        vox_in_bus.src_red = '0;
        vox_in_bus.src_green = '0;
        vox_in_bus.src_blue = '0;
        vox_in_bus.src_alpha = '0;
        vox_out_bus.ready = 1'b0;
        mode_sel = rvbm_pkg::BLEND_PAINT;
        tint_on = 1'b0;
        tint_color = {4{rvbm_pkg::FULL}};
        zero_px = '0;
        full_px = {4{8'd255}};
        // zero alphas on both sides give over a zero denominator
        warm_px = {8'd0, 8'd50, 8'd100, 8'd200};
        cool_px = {8'd0, 8'd30, 8'd20, 8'd10};

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: extremes and the zero-denominator case under every mode code
        for (int m = 0; m < 8; m++)
        begin
            write_reg(rvbm_pkg::REG_BLEND_MODE, 8'(m));
            cfg_we <= 1'b0;
            voxel_q.push_back(make_pair(zero_px, full_px));
            voxel_q.push_back(make_pair(full_px, zero_px));
            voxel_q.push_back(make_pair(warm_px, cool_px));
            wait_idle();
        end

        // long receiver hold-off while the sender keeps offering
        send_gap_max = 0;
        stall_max = 0;
        write_reg(rvbm_pkg::REG_BLEND_MODE, {5'd0, rvbm_pkg::BLEND_OVER});
        write_reg(rvbm_pkg::REG_TINT_ENABLE, 8'd1);
        write_reg(rvbm_pkg::REG_TINT_RED, 8'd128);
        cfg_we <= 1'b0;
        for (int k = 0; k < 120; k++)
            voxel_q.push_back(rand_pair());
        @(posedge clk);
        hold_off_left = 80;
        wait_idle();

        // random phases, each under its own configuration and traffic shape
        for (int p = 0; p < 12; p++)
        begin
            case (p % 3)
                0: send_gap_max = 0;
                1: send_gap_max = 3;
                default: send_gap_max = 10;
            endcase
            case ((p / 2) % 3)
                0: stall_max = 0;
                1: stall_max = 5;
                default: stall_max = 15;
            endcase
            // junk in the upper data bits must be ignored
            if (p < 8)
                write_reg(rvbm_pkg::REG_BLEND_MODE, {5'(p * 5), 3'(p)});
            else
                write_reg(rvbm_pkg::REG_BLEND_MODE, 8'($urandom_range(0, 255)));
            write_reg(rvbm_pkg::REG_TINT_ENABLE, {7'($urandom_range(0, 127)), 1'(p % 2)});
            if (p == 1)
            begin
                for (int c = 0; c < rvbm_pkg::NUM_CH; c++)
                    write_reg(3'(rvbm_pkg::REG_TINT_RED + c), 8'd0);
            end
            else if (p == 3)
            begin
                for (int c = 0; c < rvbm_pkg::NUM_CH; c++)
                    write_reg(3'(rvbm_pkg::REG_TINT_RED + c), 8'd255);
                write_reg(REG_SPARE_LO, 8'($urandom_range(0, 255)));
                write_reg(REG_SPARE_HI, 8'($urandom_range(0, 255)));
            end
            else
            begin
                for (int c = 0; c < rvbm_pkg::NUM_CH; c++)
                    write_reg(3'(rvbm_pkg::REG_TINT_RED + c), rand_chan());
            end
            cfg_we <= 1'b0;
            for (int k = 0; k < 150; k++)
                voxel_q.push_back(rand_pair());
            wait_idle();
        end

        // let any stray result surface
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatch_count == 0)
            $display("rgba_voxel_blend_modes_top regression: pass");
        else
            $display("rgba_voxel_blend_modes_top regression: fail");
        $finish;
    end

endmodule
